// ----- rtl/error_status_led_sequencer_unit_assert.svh -----
// assertion macros for the error status led sequencer
`ifndef ERROR_STATUS_LED_SEQUENCER_UNIT_ASSERT_SVH
`define ERROR_STATUS_LED_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ESLS_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esls assertion failed");

// next-cycle implication, sampled on clk, off while in reset
`define ESLS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esls assertion failed");

`endif

// ----- rtl/esls_pkg.sv -----
// shared types and constants for the error status led sequencer
package esls_pkg;

    localparam int PERIOD_WIDTH = 16;
    localparam int FLAG_WIDTH   = 7;
    localparam int RGB_WIDTH    = 3;
    localparam int LIMB_WIDTH   = 6;
    localparam int POS_WIDTH    = 3;
    localparam int PAT_COUNT    = 7;
    localparam int PHASE_COUNT  = 5;

    // item opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_EXT  = 2'd1;
    localparam logic [1:0] OP_RGB  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FAST_BLINK  = 2'd0;
    localparam logic [1:0] CFG_SLOW_BLINK  = 2'd1;
    localparam logic [1:0] CFG_CIRCLE_STEP = 2'd2;
    localparam logic [1:0] CFG_HEARTBEAT   = 2'd3;

    // configuration reset values in ms
    localparam logic [PERIOD_WIDTH-1:0] FAST_BLINK_RST  = 16'd100;
    localparam logic [PERIOD_WIDTH-1:0] SLOW_BLINK_RST  = 16'd500;
    localparam logic [PERIOD_WIDTH-1:0] CIRCLE_STEP_RST = 16'd120;
    localparam logic [PERIOD_WIDTH-1:0] HEARTBEAT_RST   = 16'd1000;

    localparam logic [PERIOD_WIDTH-1:0] ELAPSED_MAX = 16'hFFFF;

    // error flag bit positions
    localparam int FLAG_FATAL   = 0;
    localparam int FLAG_LINK    = 1;
    localparam int FLAG_VOLTAGE = 2;
    localparam int FLAG_I2C     = 3;
    localparam int FLAG_SYNC    = 4;
    localparam int FLAG_MATH    = 5;
    localparam int FLAG_CALIB   = 6;

    // rgb levels, bit0 red, bit1 green, bit2 blue
    localparam logic [RGB_WIDTH-1:0] RGB_OFF    = 3'b000;
    localparam logic [RGB_WIDTH-1:0] RGB_RED    = 3'b001;
    localparam logic [RGB_WIDTH-1:0] RGB_GREEN  = 3'b010;
    localparam logic [RGB_WIDTH-1:0] RGB_YELLOW = 3'b011;
    localparam logic [RGB_WIDTH-1:0] RGB_BLUE   = 3'b100;

    localparam logic [LIMB_WIDTH-1:0] LIMB_ALL  = 6'h3F;
    localparam logic [LIMB_WIDTH-1:0] LIMB_NONE = 6'h00;
    localparam logic [POS_WIDTH-1:0]  CIRCLE_LAST = 3'd5;

    // elapsed counter slots, the first five also own a phase bit
    typedef enum logic [2:0] {
        PAT_RED    = 3'd0,
        PAT_YELLOW = 3'd1,
        PAT_GREEN  = 3'd2,
        PAT_BLUE   = 3'd3,
        PAT_REDYEL = 3'd4,
        PAT_CIRCLE = 3'd5,
        PAT_HEART  = 3'd6
    } pat_t;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [FLAG_WIDTH-1:0] error_flags;
        logic                  limb_disabled;
        logic                  ext_value;
        logic [RGB_WIDTH-1:0]  rgb_value;
    } in_item_t;

    typedef struct packed {
        logic                  led_red;
        logic                  led_green;
        logic                  led_blue;
        logic                  active_led;
        logic [LIMB_WIDTH-1:0] limb_leds;
    } out_item_t;

    typedef struct packed {
        logic                    wr_en;
        logic [1:0]              index;
        logic [PERIOD_WIDTH-1:0] data;
    } cfg_write_t;

endpackage

// ----- rtl/esls_core.sv -----
// led state, pattern counters and per-item update logic
module esls_core
    import esls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       step_en,
    input  in_item_t   item,
    output out_item_t  result
);

    logic [PERIOD_WIDTH-1:0] fast_reg, slow_reg, circle_reg, heart_reg;

    logic                    ext_reg, ext_next;
    logic [RGB_WIDTH-1:0]    rgb_reg, rgb_next;
    logic                    hb_reg, hb_next;
    logic [LIMB_WIDTH-1:0]   limb_reg, limb_next;
    logic [PERIOD_WIDTH-1:0] elapsed_reg [PAT_COUNT];
    logic [PERIOD_WIDTH-1:0] elapsed_next [PAT_COUNT];
    logic [PHASE_COUNT-1:0]  phase_reg, phase_next;
    logic [POS_WIDTH-1:0]    pos_reg, pos_next;

    // shared blink unit controls
    logic                    blink_en;
    pat_t                    blink_pat;
    logic [PERIOD_WIDTH-1:0] blink_period;
    logic [RGB_WIDTH-1:0]    blink_rgb0, blink_rgb1;
    logic                    blink_limbs;
    logic                    circle_en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg   <= FAST_BLINK_RST;
            slow_reg   <= SLOW_BLINK_RST;
            circle_reg <= CIRCLE_STEP_RST;
            heart_reg  <= HEARTBEAT_RST;
        end
        else if (cfg.wr_en)
        begin
            case (cfg.index)
                CFG_FAST_BLINK:  fast_reg   <= cfg.data;
                CFG_SLOW_BLINK:  slow_reg   <= cfg.data;
                CFG_CIRCLE_STEP: circle_reg <= cfg.data;
                CFG_HEARTBEAT:   heart_reg  <= cfg.data;
                default: ;
            endcase
        end
    end

    // item decode and state update
    always_comb
    begin
        ext_next     = ext_reg;
        rgb_next     = rgb_reg;
        hb_next      = hb_reg;
        limb_next    = limb_reg;
        elapsed_next = elapsed_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        blink_en     = 1'b0;
        blink_pat    = PAT_RED;
        blink_period = fast_reg;
        blink_rgb0   = RGB_OFF;
        blink_rgb1   = RGB_OFF;
        blink_limbs  = 1'b0;
        circle_en    = 1'b0;

        case (item.opcode)
            OP_TICK:
            begin
                // saturating millisecond counters
                for (int i = 0; i < PAT_COUNT; i++)
                begin
                    if (elapsed_reg[i] != ELAPSED_MAX)
                        elapsed_next[i] = elapsed_reg[i] + 1'b1;
                end
                // heartbeat toggles regardless of external control
                if (elapsed_next[PAT_HEART] > heart_reg)
                begin
                    elapsed_next[PAT_HEART] = '0;
                    hb_next = ~hb_reg;
                end
                // priority decode of the error flags
                if (!ext_reg)
                begin
                    if (item.error_flags == '0)
                        rgb_next = RGB_GREEN;
                    else if (item.error_flags[FLAG_FATAL])
                    begin
                        blink_en    = 1'b1;
                        blink_pat   = PAT_RED;
                        blink_rgb0  = RGB_RED;
                        blink_limbs = 1'b1;
                    end
                    else if (item.error_flags[FLAG_LINK])
                    begin
                        blink_en     = 1'b1;
                        blink_period = slow_reg;
                        if (item.error_flags[FLAG_VOLTAGE])
                        begin
                            blink_pat   = PAT_RED;
                            blink_rgb0  = RGB_RED;
                            blink_limbs = 1'b1;
                        end
                        else if (item.error_flags[FLAG_I2C])
                        begin
                            blink_pat  = PAT_YELLOW;
                            blink_rgb1 = RGB_YELLOW;
                        end
                        else if (item.error_flags[FLAG_SYNC])
                        begin
                            blink_pat  = PAT_GREEN;
                            blink_rgb0 = RGB_RED;
                            blink_rgb1 = RGB_YELLOW;
                        end
                        else if (item.error_flags[FLAG_MATH])
                        begin
                            blink_pat  = PAT_REDYEL;
                            blink_rgb0 = RGB_RED;
                            blink_rgb1 = RGB_YELLOW;
                        end
                        else
                        begin
                            blink_pat  = PAT_BLUE;
                            blink_rgb1 = RGB_BLUE;
                        end
                    end
                    else
                    begin
                        if (item.error_flags[FLAG_VOLTAGE])
                            rgb_next = RGB_RED;
                        else if (item.error_flags[FLAG_I2C])
                            rgb_next = RGB_YELLOW;
                        else if (item.error_flags[FLAG_SYNC])
                            rgb_next = RGB_GREEN;
                        else if (item.error_flags[FLAG_MATH])
                        begin
                            blink_en     = 1'b1;
                            blink_pat    = PAT_REDYEL;
                            blink_period = slow_reg;
                            blink_rgb0   = RGB_RED;
                            blink_rgb1   = RGB_YELLOW;
                        end
                        // calibration circle runs after the colour decode
                        circle_en = item.error_flags[FLAG_CALIB] && !item.limb_disabled;
                    end
                end
            end
            OP_EXT:
            begin
                ext_next = item.ext_value;
                rgb_next = RGB_OFF;
            end
            OP_RGB:
                rgb_next = item.rgb_value;
            default: ;
        endcase

        // blink: toggle phase and restart the counter once the period has passed
        if (blink_en && (elapsed_next[blink_pat] > blink_period))
        begin
            elapsed_next[blink_pat] = '0;
            rgb_next = phase_reg[blink_pat] ? blink_rgb1 : blink_rgb0;
            if (blink_limbs && !item.limb_disabled)
                limb_next = phase_reg[blink_pat] ? LIMB_NONE : LIMB_ALL;
            phase_next[blink_pat] = ~phase_reg[blink_pat];
        end

        // circle: step one limb position
        if (circle_en && (elapsed_next[PAT_CIRCLE] > circle_reg))
        begin
            elapsed_next[PAT_CIRCLE] = '0;
            pos_next  = (pos_reg >= CIRCLE_LAST) ? '0 : pos_reg + 1'b1;
            limb_next = LIMB_WIDTH'(1) << pos_next;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg   <= 1'b0;
            rgb_reg   <= RGB_OFF;
            hb_reg    <= 1'b0;
            limb_reg  <= LIMB_NONE;
            phase_reg <= '0;
            pos_reg   <= '0;
            for (int i = 0; i < PAT_COUNT; i++)
                elapsed_reg[i] <= '0;
        end
        else if (step_en)
        begin
            ext_reg     <= ext_next;
            rgb_reg     <= rgb_next;
            hb_reg      <= hb_next;
            limb_reg    <= limb_next;
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // result reflects the state after this item
    assign result.led_red    = rgb_next[0];
    assign result.led_green  = rgb_next[1];
    assign result.led_blue   = rgb_next[2];
    assign result.active_led = hb_next;
    assign result.limb_leds  = limb_next;

endmodule

// ----- rtl/error_status_led_sequencer_unit.sv -----
// Error status LED sequencer top level. Items (1 ms ticks with error flags, or
// external-control and manual RGB commands) enter an input register, pass
// through decode and counter-update logic, and leave from an output register
// with the LED levels after that item. One item is taken every clock cycle
// unless in_stall is high; an accepted item moves from the input register to
// the output register once that is empty or not stalled. The registers are
// separated so that a result waiting on out_stall does not hold back the next
// item, and in_stall rises only when both are full and the output is stalled.
// Period registers must be written through the cfg port only while no item is
// in flight, by the user; the block itself does not enforce this.
module error_status_led_sequencer_unit
    import esls_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [1:0]              cfg_index,
    input  logic [PERIOD_WIDTH-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_item_t                in_item,
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_item_t               out_item
);

    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t core_result;
    cfg_write_t cfg;
    logic      in_accept;
    logic      advance;

    // handshake control
    assign advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign in_accept      = in_valid && !in_stall;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= core_result;
    end

    // decode and state update
    esls_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .item    (s1_item_reg),
        .result  (core_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`include "error_status_led_sequencer_unit_assert.svh"

    // a held input item must not be overwritten while the output is blocked
    `ESLS_ASSERT_IMPL(a_no_overrun, s1_valid_reg && out_valid_reg && out_stall, in_stall)
    // an accepted item always lands in the input register
    `ESLS_ASSERT_NEXT(a_accept_lands, in_accept, s1_valid_reg)
    // limb leds are all on, all off or a single circle position
    `ESLS_ASSERT_IMPL(a_limb_shape, out_valid_reg,
        $onehot0(out_item_reg.limb_leds) || (out_item_reg.limb_leds == LIMB_ALL))

endmodule
